[rtl/vm_alu_pkg.sv]
package vm_alu_pkg;

  localparam int NUM_REGS_DEF = 16;

  localparam int MODE_W  = 5;
  localparam int REG_W   = 4;
  localparam int IMM_W   = 16;
  localparam int DATA_W  = 64;
  localparam int FLAGS_W = 4;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 136;

  localparam logic [DATA_W-1:0] MASK_W1 = 64'hFFFF_FFFF_0000_FFFF;
  localparam logic [DATA_W-1:0] MASK_W2 = 64'hFFFF_0000_FFFF_FFFF;
  localparam logic [DATA_W-1:0] MASK_W3 = 64'h0000_FFFF_FFFF_FFFF;
  localparam int                SIGN_BIT = 63;
  localparam logic [DATA_W-1:0] IP_STEP  = 64'd4;

  // Flag word bit positions.
  localparam int FLAG_ZF = 0;
  localparam int FLAG_SF = 1;
  localparam int FLAG_CF = 2;
  localparam int FLAG_OF = 3;

  // Partial products of the 64x64 multiply, one 32x32 product per step.
  localparam logic [2:0] MUL_STEPS = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_NOP    = 5'd0,
    MODE_HALT   = 5'd1,
    MODE_BREAK  = 5'd2,
    MODE_MOV_RR = 5'd3,
    MODE_MOV_RI = 5'd4,
    MODE_MOV_W0 = 5'd5,
    MODE_MOV_W1 = 5'd6,
    MODE_MOV_W2 = 5'd7,
    MODE_MOV_W3 = 5'd8,
    MODE_XCHG   = 5'd9,
    MODE_LEA    = 5'd10,
    MODE_ADD_RR = 5'd11,
    MODE_ADD_RI = 5'd12,
    MODE_SUB_RR = 5'd13,
    MODE_SUB_RI = 5'd14,
    MODE_MUL_RR = 5'd15,
    MODE_MUL_RI = 5'd16
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_XCHG,
    ST_MUL,
    ST_MULF,
    ST_OUT
  } state_t;

endpackage

[rtl/vm_alu_ram.sv]
module vm_alu_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/vm_register_alu_execute.sv]
// Executes one decoded instruction per request against NUM_REGS 64-bit registers, a 64-bit
// instruction pointer and a ZF/SF/CF/OF flag word, and returns one result per request: the new
// destination value, the flags, the pointer and the running bit. The register file sits in two
// copies of a one-write, one-read RAM so that both operands are read in the accept cycle; a
// per-register valid bit makes every register read as zero after reset, so no clearing pass is
// needed. Most instructions take an accept and an execute step; exchange adds ST_XCHG, as its
// second register write needs the single write port. Multiply adds ST_MUL and ST_MULF: the 64x64
// product is built from four 32x32 partial products on one registered multiplier, accumulated
// one per cycle. A result waits in the output register while the block takes the next request.
module vm_register_alu_execute #(
  parameter int NUM_REGS = vm_alu_pkg::NUM_REGS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // dst_reg[3:0], src_reg[7:4], imm[23:8]
  input  logic [vm_alu_pkg::IN_TDATA_W-1:0]  s_tdata,
  // mode[4:0]
  input  logic [vm_alu_pkg::MODE_W-1:0]      s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // written_value[63:0], flags_out[67:64], next_ip[131:68], still_running[132], zero[135:133]
  output logic [vm_alu_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import vm_alu_pkg::*;

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  state_t state_q, state_next;

  logic [MODE_W-1:0] mode_q;
  logic [IDX_W-1:0]  d_q, s_q;
  logic [IMM_W-1:0]  imm_q;
  logic [IDX_W-1:0]  d_in, s_in;

  logic [DATA_W-1:0]  ip_q, ip_next;
  logic [FLAGS_W-1:0] flags_q, flags_next;
  logic               run_q, run_next;
  logic [NUM_REGS-1:0] vld_q;

  logic [DATA_W-1:0] rd_a, rd_b, a_val, b_reg, imm_ext, op_b;
  logic [DATA_W-1:0] opa_q, opb_q, res_q;

  logic [2:0]          mcnt_q;
  logic [1:0]          psh_q;
  logic [DATA_W-1:0]   prod_q;
  logic [2*DATA_W-1:0] acc_q, acc_add;
  logic [31:0]         mul_a, mul_b;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [DATA_W-1:0] wr_data;
  logic              done, out_free, out_load;
  logic [DATA_W-1:0] done_val;

  logic [DATA_W-1:0]  out_val_q, out_ip_q;
  logic [FLAGS_W-1:0] out_flags_q;
  logic               out_run_q;

  logic               accept;
  logic [DATA_W:0]    sum;
  logic [DATA_W-1:0]  diff, mres;
  logic               is_rr;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state_q == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign out_load = done && out_free;
  assign m_tdata  = {3'b000, out_run_q, out_ip_q, out_flags_q, out_val_q};

  // Register indexes wrap modulo NUM_REGS; a 4-bit index needs at most seven if NUM_REGS >= 2.
  always_comb begin
    logic [8:0] td, ts;
    td = {5'b0, s_tdata[REG_W-1:0]};
    ts = {5'b0, s_tdata[2*REG_W-1:REG_W]};
    for (int i = 0; i < 8; i++) begin
      if (td >= 9'(NUM_REGS)) td = td - 9'(NUM_REGS);
      if (ts >= 9'(NUM_REGS)) ts = ts - 9'(NUM_REGS);
    end
    d_in = td[IDX_W-1:0];
    s_in = ts[IDX_W-1:0];
  end

  vm_alu_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_a (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data), .raddr(d_in), .rdata(rd_a)
  );

  vm_alu_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_ram_b (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data), .raddr(s_in), .rdata(rd_b)
  );

  assign a_val   = vld_q[d_q] ? rd_a : '0;
  assign b_reg   = vld_q[s_q] ? rd_b : '0;
  assign imm_ext = {{(DATA_W-IMM_W){1'b0}}, imm_q};
  assign is_rr   = (mode_q == MODE_ADD_RR) || (mode_q == MODE_SUB_RR) ||
                   (mode_q == MODE_MUL_RR) || (mode_q == MODE_XCHG);
  assign op_b    = is_rr ? b_reg : imm_ext;
  assign sum     = {1'b0, a_val} + {1'b0, op_b};
  assign diff    = a_val - op_b;
  assign mres    = acc_q[DATA_W-1:0];

  assign mul_a = mcnt_q[1] ? opa_q[63:32] : opa_q[31:0];
  assign mul_b = mcnt_q[0] ? opb_q[63:32] : opb_q[31:0];

  always_comb begin
    case (psh_q)
      2'd0:    acc_add = {64'b0, prod_q[DATA_W-1:0]};
      2'd1:    acc_add = {32'b0, prod_q[DATA_W-1:0], 32'b0};
      2'd2:    acc_add = {prod_q[DATA_W-1:0], 64'b0};
      default: acc_add = '0;
    endcase
  end

  always_comb begin
    logic [DATA_W-1:0] wv;
    logic              we_d;
    state_next = state_q;
    wr_en      = 1'b0;
    wr_addr    = d_q;
    wr_data    = '0;
    flags_next = flags_q;
    ip_next    = ip_q;
    run_next   = run_q;
    done       = 1'b0;
    done_val   = res_q;
    wv         = a_val;
    we_d       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        done = 1'b1;
        if (run_q) begin
          ip_next = ip_q + IP_STEP;
          case (mode_q)
            MODE_HALT: begin
              run_next = 1'b0;
              ip_next  = ip_q;
            end
            MODE_MOV_RR: begin
              wv = b_reg;  we_d = 1'b1;
            end
            MODE_MOV_RI, MODE_MOV_W0: begin
              wv = imm_ext;  we_d = 1'b1;
            end
            MODE_MOV_W1: begin
              wv = (a_val & MASK_W1) | (imm_ext << 16);  we_d = 1'b1;
            end
            MODE_MOV_W2: begin
              wv = (a_val & MASK_W2) | (imm_ext << 32);  we_d = 1'b1;
            end
            MODE_MOV_W3: begin
              wv = (a_val & MASK_W3) | (imm_ext << 48);  we_d = 1'b1;
            end
            MODE_XCHG: begin
              wv = b_reg;  we_d = 1'b1;  done = 1'b0;
              state_next = ST_XCHG;
            end
            MODE_LEA: begin
              wv = b_reg + {56'b0, imm_q[7:0]};  we_d = 1'b1;
            end
            MODE_ADD_RR, MODE_ADD_RI: begin
              wv = sum[DATA_W-1:0];  we_d = 1'b1;
              flags_next[FLAG_ZF] = (wv == '0);
              flags_next[FLAG_SF] = wv[SIGN_BIT];
              flags_next[FLAG_CF] = sum[DATA_W];
              flags_next[FLAG_OF] = (a_val[SIGN_BIT] ^ wv[SIGN_BIT]) &
                                    (op_b[SIGN_BIT] ^ wv[SIGN_BIT]);
            end
            MODE_SUB_RR, MODE_SUB_RI: begin
              wv = diff;  we_d = 1'b1;
              flags_next[FLAG_ZF] = (wv == '0);
              flags_next[FLAG_SF] = wv[SIGN_BIT];
              flags_next[FLAG_CF] = (a_val < op_b);
              flags_next[FLAG_OF] = (a_val[SIGN_BIT] ^ op_b[SIGN_BIT]) &
                                    (a_val[SIGN_BIT] ^ wv[SIGN_BIT]);
            end
            MODE_MUL_RR, MODE_MUL_RI: begin
              done = 1'b0;
              state_next = ST_MUL;
            end
            default: begin
            end
          endcase
        end
        wr_en    = we_d;
        wr_data  = wv;
        done_val = wv;
      end
      ST_XCHG: begin
        wr_en    = 1'b1;
        wr_addr  = s_q;
        wr_data  = opa_q;
        done     = 1'b1;
        done_val = opb_q;
      end
      ST_MUL: begin
        if (mcnt_q == MUL_STEPS) state_next = ST_MULF;
      end
      ST_MULF: begin
        wr_en    = 1'b1;
        wr_data  = mres;
        done     = 1'b1;
        done_val = mres;
        flags_next[FLAG_ZF] = (mres == '0);
        flags_next[FLAG_SF] = mres[SIGN_BIT];
        flags_next[FLAG_CF] = |acc_q[2*DATA_W-1:DATA_W];
        flags_next[FLAG_OF] = |acc_q[2*DATA_W-1:DATA_W];
      end
      ST_OUT: begin
        done = 1'b1;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (done) state_next = out_free ? ST_IDLE : ST_OUT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state_q  <= ST_IDLE;
      ip_q     <= '0;
      flags_q  <= '0;
      run_q    <= 1'b1;
      vld_q    <= '0;
      m_tvalid <= 1'b0;
      mcnt_q   <= '0;
    end else begin
      state_q <= state_next;
      ip_q    <= ip_next;
      flags_q <= flags_next;
      run_q   <= run_next;
      if (wr_en) vld_q[wr_addr] <= 1'b1;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state_q == ST_EXEC) begin
        mcnt_q <= '0;
      end else if (state_q == ST_MUL) begin
        mcnt_q <= mcnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= s_tuser;
      d_q    <= d_in;
      s_q    <= s_in;
      imm_q  <= s_tdata[IN_TDATA_W-1:2*REG_W];
    end
    if (state_q == ST_EXEC) begin
      opa_q <= a_val;
      opb_q <= op_b;
      acc_q <= '0;
    end
    if (state_q == ST_MUL) begin
      prod_q <= {32'b0, mul_a} * {32'b0, mul_b};
      psh_q  <= {1'b0, mcnt_q[1]} + {1'b0, mcnt_q[0]};
      // The product registered in the previous step is added in this one.
      if (mcnt_q != 3'd0) acc_q <= acc_q + acc_add;
    end
    if (out_load) begin
      out_val_q   <= done_val;
      out_flags_q <= flags_next;
      out_ip_q    <= ip_next;
      out_run_q   <= run_next;
    end else if (done) begin
      res_q <= done_val;
    end
  end

`ifndef SYNTHESIS
  // Operands are read in the accept cycle, so no register write may land in that cycle.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state_q == ST_IDLE) |-> !wr_en) else $error("register write during operand read");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    !run_q |=> !run_q && (ip_q == $past(ip_q)) && (flags_q == $past(flags_q)))
    else $error("state changed after halt");

  a_mul_bound: assert property (@(posedge clk) disable iff (rst)
    (state_q == ST_MUL) |-> (mcnt_q <= MUL_STEPS)) else $error("multiply step overrun");
`endif

endmodule
